### rtl/bbr_pkg.sv
// Shared types and constants for the block bit rotate cipher.
// Holds the sequencer control word, its program ROM and the register map.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package bbr_pkg;

  // Field widths of the channel payloads and the configuration port.
  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 7;
  localparam int BitCntW  = 4;
  localparam int EmitCntW = 3;

  // Register map of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_DIRECTION  = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_BLOCK_BITS = 1'd1;

  // Block length after reset.
  localparam logic [CfgDataW-1:0] ResetBlockBits = 7'd4;

  // Datapath operation selected by one control word.
  typedef enum logic [2:0] {
    OP_NOP,
    OP_FETCH,
    OP_SHIFT,
    OP_CLOSE,
    OP_DRAIN
  } op_e;

  // Branch conditions tested after the operation of a step.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_BLOCK_FULL,
    COND_BITS_LEFT,
    COND_PEND_LEFT,
    COND_EOM_OPEN
  } cond_e;

  // Program addresses.
  typedef enum logic [2:0] {
    STEP_FETCH,
    STEP_SHIFT,
    STEP_CLOSE,
    STEP_DRAIN,
    STEP_FLUSH
  } step_e;

  // One control word: an operation, two prioritized branches and a fall-through.
  typedef struct packed {
    op_e   op;
    cond_e cond_a;
    step_e tgt_a;
    cond_e cond_b;
    step_e tgt_b;
    step_e tgt_else;
  } ucode_t;

  // Program ROM of the sequencer.
  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    case (s)
      STEP_FETCH: w = '{op: OP_FETCH, cond_a: COND_NEVER, tgt_a: STEP_FETCH,
                        cond_b: COND_NEVER, tgt_b: STEP_FETCH, tgt_else: STEP_SHIFT};
      STEP_SHIFT: w = '{op: OP_SHIFT, cond_a: COND_BLOCK_FULL, tgt_a: STEP_CLOSE,
                        cond_b: COND_BITS_LEFT, tgt_b: STEP_SHIFT, tgt_else: STEP_FLUSH};
      STEP_CLOSE: w = '{op: OP_CLOSE, cond_a: COND_NEVER, tgt_a: STEP_CLOSE,
                        cond_b: COND_NEVER, tgt_b: STEP_CLOSE, tgt_else: STEP_DRAIN};
      STEP_DRAIN: w = '{op: OP_DRAIN, cond_a: COND_PEND_LEFT, tgt_a: STEP_DRAIN,
                        cond_b: COND_BITS_LEFT, tgt_b: STEP_SHIFT, tgt_else: STEP_FLUSH};
      STEP_FLUSH: w = '{op: OP_NOP, cond_a: COND_EOM_OPEN, tgt_a: STEP_CLOSE,
                        cond_b: COND_NEVER, tgt_b: STEP_FLUSH, tgt_else: STEP_FETCH};
      default:    w = '{op: OP_NOP, cond_a: COND_NEVER, tgt_a: STEP_FETCH,
                        cond_b: COND_NEVER, tgt_b: STEP_FETCH, tgt_else: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/bbr_in_if.sv
// Input channel of the block bit rotate cipher: valid/ready plus one message byte.
// Depends on bbr_pkg for the byte width.
`default_nettype none

interface bbr_in_if;
  logic                      valid;
  logic                      ready;
  logic [bbr_pkg::ByteW-1:0] data_byte;
  logic                      end_of_message;

  modport source (output valid, output data_byte, output end_of_message, input ready);
  modport sink   (input valid, input data_byte, input end_of_message, output ready);
endinterface

`default_nettype wire

### rtl/bbr_out_if.sv
// Output channel of the block bit rotate cipher: valid/ready plus one result byte.
// Depends on bbr_pkg for the byte width.
`default_nettype none

interface bbr_out_if;
  logic                      valid;
  logic                      ready;
  logic [bbr_pkg::ByteW-1:0] out_byte;
  logic                      out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

### rtl/block_bit_rotate_cipher_unit.sv
// Block bit rotate cipher: microcoded sequencer over a bit-serial gather path.
// Depends on bbr_pkg, bbr_in_if and bbr_out_if.
//
// Usage: message bytes arrive on in_i, bit 7 first in stream order, with
// end_of_message on the final byte. The bit stream is cut into blocks of
// block_bits bits, each block is rotated by one bit (right to encrypt, left
// to decrypt) and the stream is repacked into bytes on out_o, the final byte
// of a message carrying out_last. Configuration is written through
// cfg_we_i/cfg_idx_i/cfg_data_i between messages or while the block is idle.
// Steps: each word passes through the fetch step, the shift step once per bit
// (one bit a cycle) and the flush step; every block it completes adds the
// close step plus one drain step for each output byte that receives bits of
// the block. The bit-serial shift step sets the floor on the time per word.
// A closed block reaches out_o through the drain step and the output register.
// The output register frees the datapath as soon as it is loaded, so the
// next byte is prepared while the receiver stalls; the drain step holds only
// when a new byte is complete and the output register is still occupied.
// Reset clears all counters, the open block and the registers (encrypt,
// block length 4); the block is ready for input on the first cycle after it.
`default_nettype none

module block_bit_rotate_cipher_unit #(
  parameter int MAX_BLOCK_BITS = 64
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bbr_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [bbr_pkg::CfgDataW-1:0]    cfg_data_i,
  bbr_in_if.sink                               in_i,
  bbr_out_if.source                            out_o
);

  localparam int PW = (MAX_BLOCK_BITS < bbr_pkg::ByteW) ? bbr_pkg::ByteW : MAX_BLOCK_BITS;
  localparam int CW = $clog2(MAX_BLOCK_BITS + 1);
  localparam int SW = $clog2(PW + 1);
  localparam logic [bbr_pkg::CfgDataW-1:0] MaxLen = bbr_pkg::CfgDataW'(MAX_BLOCK_BITS);

  // Configuration registers.
  logic                         direction_q;
  logic [bbr_pkg::CfgDataW-1:0] block_bits_q;

  // Sequencer and datapath registers.
  bbr_pkg::step_e                step_q, step_d;
  logic [bbr_pkg::ByteW-1:0]     shift_q, shift_d;
  logic [bbr_pkg::BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic                          eom_q, eom_d;
  logic [MAX_BLOCK_BITS-1:0]     gather_q, gather_d;
  logic [CW-1:0]                 gather_cnt_q, gather_cnt_d;
  logic [PW-1:0]                 pend_q, pend_d;
  logic [CW-1:0]                 pend_cnt_q, pend_cnt_d;
  logic [bbr_pkg::ByteW-1:0]     emit_q, emit_d;
  logic [bbr_pkg::EmitCntW-1:0]  emit_cnt_q, emit_cnt_d;
  logic [bbr_pkg::ByteW-1:0]     out_byte_q, out_byte_d;
  logic                          out_last_q, out_last_d;
  logic                          out_valid_q, out_valid_d;

  // Decode and datapath helpers.
  bbr_pkg::ucode_t               uw;
  logic                          op_done;
  logic [CW-1:0]                 eff_len;
  logic [CW-1:0]                 gather_inc;
  logic                          block_full;
  logic [SW-1:0]                 align_sh;
  logic [PW-1:0]                 va, win, rot_enc, rot_dec, rot;
  logic [bbr_pkg::BitCntW-1:0]   room, take_k, fill;
  logic [bbr_pkg::ByteW-1:0]     top8, take, merged;
  logic                          byte_done, out_free, drain_stall;
  logic [CW-1:0]                 pend_left;
  logic                          cond_a_hit, cond_b_hit;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q  <= 1'b0;
      block_bits_q <= bbr_pkg::ResetBlockBits;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bbr_pkg::REG_DIRECTION:  direction_q  <= cfg_data_i[0];
        bbr_pkg::REG_BLOCK_BITS: block_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control word of the current step.
  assign uw = bbr_pkg::ucode_rom(step_q);

  // Effective block length: zero counts as one, larger values saturate.
  always_comb begin
    if (block_bits_q == '0) begin
      eff_len = CW'(1);
    end else if (block_bits_q > MaxLen) begin
      eff_len = CW'(MAX_BLOCK_BITS);
    end else begin
      eff_len = CW'(block_bits_q);
    end
  end

  assign gather_inc = gather_cnt_q + CW'(1);
  assign block_full = (gather_inc >= eff_len);

  // Rotation of the open block, left aligned so the first stream bit is the MSB.
  assign align_sh = SW'(PW) - SW'(gather_cnt_q);
  assign va       = PW'(gather_q) << align_sh;
  assign win      = {PW{1'b1}} << align_sh;
  assign rot_enc  = ((va >> 1) & win) | {gather_q[0], {(PW-1){1'b0}}};
  assign rot_dec  = (va << 1) | (PW'(va[PW-1]) << align_sh);
  assign rot      = direction_q ? rot_dec : rot_enc;

  // Drain: move as many pending bits as fit into the partial output byte.
  assign room      = 4'(bbr_pkg::ByteW) - 4'(emit_cnt_q);
  assign take_k    = (8'(pend_cnt_q) < 8'(room)) ? 4'(pend_cnt_q) : room;
  assign top8      = pend_q[PW-1 -: bbr_pkg::ByteW];
  assign take      = top8 >> (4'(bbr_pkg::ByteW) - take_k);
  assign merged    = (emit_q << take_k) | take;
  assign fill      = 4'(emit_cnt_q) + take_k;
  assign byte_done = (fill == 4'(bbr_pkg::ByteW));
  assign pend_left = pend_cnt_q - CW'(take_k);
  assign out_free  = !out_valid_q || out_o.ready;
  assign drain_stall = byte_done && !out_free;

  // Input handshake is open only in the fetch step.
  assign in_i.ready = (uw.op == bbr_pkg::OP_FETCH);

  // Datapath controls driven by the current control word.
  always_comb begin
    op_done      = 1'b1;
    shift_d      = shift_q;
    bit_cnt_d    = bit_cnt_q;
    eom_d        = eom_q;
    gather_d     = gather_q;
    gather_cnt_d = gather_cnt_q;
    pend_d       = pend_q;
    pend_cnt_d   = pend_cnt_q;
    emit_d       = emit_q;
    emit_cnt_d   = emit_cnt_q;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    unique case (uw.op)
      bbr_pkg::OP_FETCH: begin
        if (in_i.valid) begin
          shift_d   = in_i.data_byte;
          eom_d     = in_i.end_of_message;
          bit_cnt_d = 4'(bbr_pkg::ByteW);
        end else begin
          op_done = 1'b0;
        end
      end
      bbr_pkg::OP_SHIFT: begin
        gather_d     = {gather_q[MAX_BLOCK_BITS-2:0], shift_q[bbr_pkg::ByteW-1]};
        shift_d      = shift_q << 1;
        gather_cnt_d = gather_inc;
        bit_cnt_d    = bit_cnt_q - 4'd1;
      end
      bbr_pkg::OP_CLOSE: begin
        pend_d       = rot;
        pend_cnt_d   = gather_cnt_q;
        gather_d     = '0;
        gather_cnt_d = '0;
      end
      bbr_pkg::OP_DRAIN: begin
        if (drain_stall) begin
          op_done = 1'b0;
        end else begin
          pend_d     = pend_q << take_k;
          pend_cnt_d = pend_left;
          if (byte_done) begin
            emit_d      = '0;
            emit_cnt_d  = '0;
            out_byte_d  = merged;
            out_last_d  = eom_q && (bit_cnt_q == '0) && (gather_cnt_q == '0) &&
                          (pend_left == '0);
            out_valid_d = 1'b1;
          end else begin
            emit_d     = merged;
            emit_cnt_d = 3'(fill);
          end
        end
      end
      default: ;
    endcase
  end

  // Branch condition evaluation.
  function automatic logic cond_eval(bbr_pkg::cond_e c, logic full,
                                     logic bits_left, logic pend_open, logic eom_open);
    logic r;
    case (c)
      bbr_pkg::COND_BLOCK_FULL: r = full;
      bbr_pkg::COND_BITS_LEFT:  r = bits_left;
      bbr_pkg::COND_PEND_LEFT:  r = pend_open;
      bbr_pkg::COND_EOM_OPEN:   r = eom_open;
      default:                  r = 1'b0;
    endcase
    return r;
  endfunction

  // Next step of the sequencer.
  always_comb begin
    cond_a_hit = cond_eval(uw.cond_a, block_full, bit_cnt_d != '0, pend_cnt_d != '0,
                           eom_q && (gather_cnt_q != '0));
    cond_b_hit = cond_eval(uw.cond_b, block_full, bit_cnt_d != '0, pend_cnt_d != '0,
                           eom_q && (gather_cnt_q != '0));
    if (!op_done) begin
      step_d = step_q;
    end else if (cond_a_hit) begin
      step_d = uw.tgt_a;
    end else if (cond_b_hit) begin
      step_d = uw.tgt_b;
    end else begin
      step_d = uw.tgt_else;
    end
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= bbr_pkg::STEP_FETCH;
      bit_cnt_q    <= '0;
      eom_q        <= 1'b0;
      gather_q     <= '0;
      gather_cnt_q <= '0;
      pend_cnt_q   <= '0;
      emit_q       <= '0;
      emit_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      step_q       <= step_d;
      bit_cnt_q    <= bit_cnt_d;
      eom_q        <= eom_d;
      gather_q     <= gather_d;
      gather_cnt_q <= gather_cnt_d;
      pend_cnt_q   <= pend_cnt_d;
      emit_q       <= emit_d;
      emit_cnt_q   <= emit_cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    shift_q    <= shift_d;
    pend_q     <= pend_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;

  // Between words the open block is shorter than the longest block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == bbr_pkg::STEP_FETCH) |-> (gather_cnt_q < CW'(MAX_BLOCK_BITS)))
    else $error("open block too long between words");

  // Whole bytes in: held bits always total a multiple of eight between words.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == bbr_pkg::STEP_FETCH) |->
      ((3'(gather_cnt_q) + emit_cnt_q) == 3'd0) && (pend_cnt_q == '0))
    else $error("held bit count not byte aligned between words");

  // The last byte leaves nothing behind and hands over to the flush step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == bbr_pkg::OP_DRAIN && !drain_stall && byte_done && out_last_d) |=>
      (step_q == bbr_pkg::STEP_FLUSH) && (gather_cnt_q == '0) && (emit_cnt_q == '0))
    else $error("last byte sent with bits still held");

endmodule

`default_nettype wire
